[sv/fcss_pkg.sv]
package fcss_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [5:0] TYPE_REG_OFFSET = 6'h31;

  localparam logic [3:0] SW_MOTOR_OFF = 4'h8;
  localparam logic [3:0] SW_MOTOR_ON  = 4'h9;
  localparam logic [3:0] SW_DRIVE_0   = 4'hA;
  localparam logic [3:0] SW_DRIVE_1   = 4'hB;
  localparam logic [3:0] SW_Q6_CLEAR  = 4'hC;
  localparam logic [3:0] SW_Q6_SET    = 4'hD;
  localparam logic [3:0] SW_Q7_CLEAR  = 4'hE;
  localparam logic [3:0] SW_Q7_SET    = 4'hF;

  localparam logic [7:0] SPINDOWN_RESET   = 8'd60;
  localparam logic [7:0] HANDSHAKE_BUSY   = 8'hC0;
  localparam logic [7:0] HANDSHAKE_READY  = 8'h80;
  localparam logic [7:0] DATA_NOT_READY   = 8'hFF;
  localparam logic [4:0] MODE_MASK        = 5'h1F;
  localparam int unsigned MODE_IMMEDIATE  = 2;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] offset;
    logic [7:0] write_data;
    logic [7:0] drive_data;
    logic       drive_sense;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       step_valid;
    logic [3:0] step_arg;
    logic       write_valid;
    logic [7:0] write_byte;
    logic       read_taken;
    logic       flush;
    logic       drive_is_35;
    logic       drive_number;
    logic       motor_running;
    logic [3:0] sense_code;
  } out_item_t;

  typedef struct packed {
    logic       q6_latch;
    logic       q7_latch;
    logic       motor_flag;
    logic       spindown_flag;
    logic [7:0] spindown_left;
    logic       selected_drive;
    logic [4:0] mode_bits;
    logic       enable_two;
    logic [1:0] handshake_count;
    logic [3:0] phase_lines;
    logic       control_35;
    logic       select_35;
  } ctrl_state_t;

endpackage

[sv/floppy_controller_soft_switches_core.sv]
// Soft-switch floppy controller core.
// The input channel carries one transaction per bus read, bus write or
// frame tick; every input transaction produces exactly one result
// transaction on the output channel, in order.
// The result is computed in the cycle the input is accepted and is
// registered in the result queue before it appears on the output.
// A new input can be accepted every cycle unless the result queue is
// full; the sustained rate is one transaction per cycle, set by the
// combinational switch decode and the two-entry result queue.
// When the receiver stalls, up to two results are held and input ready
// falls only once both entries are occupied.
// The spindown frame count is written through cfg_write_en and
// cfg_write_data, and should only be written while the block is idle.
// Synchronous reset clears all switch state and the result queue and
// sets the spindown frame count to 60.
module floppy_controller_soft_switches_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fcss_pkg::out_item_t out_data,
  input  logic                cfg_write_en,
  input  logic [7:0]          cfg_write_data
);
  import fcss_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  out_item_t   result;
  logic [7:0]  spindown_frames;
  logic        full;
  logic        accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  fcss_logic u_logic (
    .state           (state),
    .item            (in_data),
    .spindown_frames (spindown_frames),
    .state_next      (state_next),
    .result          (result)
  );

  fcss_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= '0;
      spindown_frames <= SPINDOWN_RESET;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (cfg_write_en) begin
        spindown_frames <= cfg_write_data;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Input stalled while no result is pending.");

  a_spindown_needs_motor: assert property (@(posedge clk) disable iff (rst)
    state.spindown_flag |-> state.motor_flag)
    else $error("Spindown active with the motor off.");

  a_step_needs_motor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.step_valid) |-> out_data.motor_running)
    else $error("Step strobe issued with the motor off.");
`endif

endmodule

[sv/fcss_logic.sv]
module fcss_logic (
  input  fcss_pkg::ctrl_state_t state,
  input  fcss_pkg::in_item_t    item,
  input  logic [7:0]            spindown_frames,
  output fcss_pkg::ctrl_state_t state_next,
  output fcss_pkg::out_item_t   result
);
  import fcss_pkg::*;

  ctrl_state_t s;
  out_item_t   r;
  logic        type_reg;
  logic        do_touch;
  logic [3:0]  loc;
  logic [1:0]  p;
  logic        on;
  logic        st;
  logic [7:0]  left_dec;

  assign type_reg = (item.offset == TYPE_REG_OFFSET);
  assign do_touch = ((item.op == OP_READ) || (item.op == OP_WRITE)) && !type_reg;
  assign loc      = item.offset[3:0];
  assign p        = loc[2:1];
  assign on       = loc[0];
  assign left_dec = (state.spindown_left != 8'd0) ? state.spindown_left - 8'd1 : 8'd0;

  always_comb begin
    s  = state;
    r  = '0;
    st = 1'b0;

    if (do_touch) begin
      if (!loc[3]) begin
        s.phase_lines[p] = on;
        if (s.motor_flag) begin
          if (s.select_35) begin
            if ((p == 2'd3) && on) begin
              r.step_valid = 1'b1;
              r.step_arg   = {s.phase_lines[1], s.phase_lines[0], s.control_35,
                              s.phase_lines[2]};
            end
          end else if (on) begin
            r.step_valid = 1'b1;
            r.step_arg   = {2'b00, p};
          end
        end else begin
          s.enable_two = s.phase_lines[1] & s.phase_lines[3];
        end
      end else begin
        unique case (loc)
          SW_MOTOR_OFF: begin
            if (s.mode_bits[MODE_IMMEDIATE]) begin
              s.spindown_flag = 1'b0;
              s.motor_flag    = 1'b0;
            end else if (s.motor_flag && !s.spindown_flag) begin
              s.spindown_flag = 1'b1;
              s.spindown_left = spindown_frames;
            end
          end
          SW_MOTOR_ON: begin
            s.motor_flag    = 1'b1;
            s.spindown_flag = 1'b0;
          end
          SW_DRIVE_0:  s.selected_drive = 1'b0;
          SW_DRIVE_1:  s.selected_drive = 1'b1;
          SW_Q6_CLEAR: s.q6_latch = 1'b0;
          SW_Q6_SET:   s.q6_latch = 1'b1;
          SW_Q7_CLEAR: s.q7_latch = 1'b0;
          default:     s.q7_latch = 1'b1;
        endcase
      end
    end

    unique case (item.op)
      OP_READ: begin
        if (type_reg) begin
          r.read_data = {s.control_35, s.select_35, 6'b0};
        end else if (item.offset[0]) begin
          r.read_data = 8'h00;
        end else if (!s.q7_latch && !s.q6_latch) begin
          if (s.enable_two || !s.motor_flag) begin
            r.read_data = DATA_NOT_READY;
          end else begin
            r.read_data  = item.drive_data;
            r.read_taken = 1'b1;
          end
        end else if (!s.q7_latch && s.q6_latch) begin
          if (s.enable_two) begin
            st = 1'b1;
          end else if (s.select_35) begin
            st = s.motor_flag ? item.drive_sense : 1'b1;
          end else begin
            st = item.drive_sense;
          end
          r.read_data = {st, 1'b0, s.motor_flag, s.mode_bits & MODE_MASK};
        end else if (s.q7_latch && !s.q6_latch) begin
          if (s.enable_two) begin
            if (s.handshake_count == 2'd3) begin
              s.handshake_count = 2'd0;
              r.read_data       = HANDSHAKE_READY;
            end else begin
              s.handshake_count = s.handshake_count + 2'd1;
              r.read_data       = HANDSHAKE_BUSY;
            end
          end else begin
            r.read_data = HANDSHAKE_READY;
          end
        end else begin
          r.read_data = 8'h00;
        end
      end
      OP_WRITE: begin
        if (type_reg) begin
          s.control_35 = item.write_data[7];
          s.select_35  = item.write_data[6];
        end else if (item.offset[0] && s.q7_latch && s.q6_latch) begin
          if (!s.motor_flag) begin
            s.mode_bits = item.write_data[4:0];
          end else if (!s.enable_two) begin
            r.write_valid = 1'b1;
            r.write_byte  = item.write_data;
          end
        end
      end
      OP_TICK: begin
        if (s.motor_flag && s.spindown_flag) begin
          s.spindown_left = left_dec;
          if (left_dec == 8'd0) begin
            s.motor_flag    = 1'b0;
            s.spindown_flag = 1'b0;
          end
        end
        r.flush = !s.motor_flag || s.spindown_flag;
      end
      default: begin
      end
    endcase

    r.drive_is_35   = s.select_35;
    r.drive_number  = s.selected_drive;
    r.motor_running = s.motor_flag;
    r.sense_code    = {s.phase_lines[2], s.phase_lines[1], s.phase_lines[0], s.control_35};
  end

  assign state_next = s;
  assign result     = r;

endmodule

[sv/fcss_out_queue.sv]
module fcss_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fcss_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_ready,
  output fcss_pkg::out_item_t out_data
);
  import fcss_pkg::*;

  out_item_t head;
  out_item_t tail;
  logic      head_valid;
  logic      tail_valid;
  logic      pop;

  assign pop       = head_valid && out_ready;
  assign full      = tail_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      if (pop && push) begin
        head <= push_data;
      end else if (pop) begin
        head       <= tail;
        head_valid <= tail_valid;
        tail_valid <= 1'b0;
      end else if (push) begin
        if (!head_valid) begin
          head       <= push_data;
          head_valid <= 1'b1;
        end else begin
          tail       <= push_data;
          tail_valid <= 1'b1;
        end
      end
    end
  end

endmodule

[verif/fcss_result_checker.sv]
module fcss_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fcss_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fcss_pkg::out_item_t out_data,
  input  logic                cfg_write_en,
  input  logic [7:0]          cfg_write_data,
  output int                  error_count,
  output int                  pending
);
  import fcss_pkg::*;

  ctrl_state_t sw_state;
  logic [7:0]  spindown_frames;
  out_item_t   pending_responses[$];
  logic        step_fire;
  logic [3:0]  step_code;
  int          fail_total = 0;

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_total++;
    end
  endtask

  task automatic apply_switch(input logic [3:0] sw);
    logic [1:0] phase;
    logic       on;
    if (!sw[3]) begin
      phase = sw[2:1];
      on = sw[0];
      sw_state.phase_lines[phase] = on;
      if (sw_state.motor_flag) begin
        if (sw_state.select_35) begin
          if (phase == 2'd3 && on) begin
            step_fire = 1'b1;
            step_code = {sw_state.phase_lines[1], sw_state.phase_lines[0],
                         sw_state.control_35, sw_state.phase_lines[2]};
          end
        end else if (on) begin
          step_fire = 1'b1;
          step_code = {2'b00, phase};
        end
      end else begin
        sw_state.enable_two = sw_state.phase_lines[1] & sw_state.phase_lines[3];
      end
    end else begin
      case (sw)
        SW_MOTOR_OFF: begin
          if (sw_state.mode_bits[MODE_IMMEDIATE]) begin
            sw_state.spindown_flag = 1'b0;
            sw_state.motor_flag = 1'b0;
          end else if (sw_state.motor_flag && !sw_state.spindown_flag) begin
            sw_state.spindown_flag = 1'b1;
            sw_state.spindown_left = spindown_frames;
          end
        end
        SW_MOTOR_ON: begin
          sw_state.motor_flag = 1'b1;
          sw_state.spindown_flag = 1'b0;
        end
        SW_DRIVE_0:  sw_state.selected_drive = 1'b0;
        SW_DRIVE_1:  sw_state.selected_drive = 1'b1;
        SW_Q6_CLEAR: sw_state.q6_latch = 1'b0;
        SW_Q6_SET:   sw_state.q6_latch = 1'b1;
        SW_Q7_CLEAR: sw_state.q7_latch = 1'b0;
        default:     sw_state.q7_latch = 1'b1;
      endcase
    end
  endtask

  task automatic predict_switch_response(input in_item_t it, output out_item_t r);
    logic status_bit;
    r = '0;
    step_fire = 1'b0;
    step_code = '0;
    case (it.op)
      OP_READ: begin
        if (it.offset == TYPE_REG_OFFSET) begin
          r.read_data = {sw_state.control_35, sw_state.select_35, 6'b000000};
        end else begin
          apply_switch(it.offset[3:0]);
          if (!it.offset[0]) begin
            case ({sw_state.q7_latch, sw_state.q6_latch})
              2'b00: begin
                if (sw_state.enable_two || !sw_state.motor_flag) begin
                  r.read_data = DATA_NOT_READY;
                end else begin
                  r.read_data = it.drive_data;
                  r.read_taken = 1'b1;
                end
              end
              2'b01: begin
                if (sw_state.enable_two) begin
                  status_bit = 1'b1;
                end else if (sw_state.select_35) begin
                  status_bit = sw_state.motor_flag ? it.drive_sense : 1'b1;
                end else begin
                  status_bit = it.drive_sense;
                end
                r.read_data = {status_bit, 1'b0, sw_state.motor_flag, sw_state.mode_bits};
              end
              2'b10: begin
                if (sw_state.enable_two) begin
                  if (sw_state.handshake_count == 2'd3) begin
                    sw_state.handshake_count = 2'd0;
                    r.read_data = HANDSHAKE_READY;
                  end else begin
                    sw_state.handshake_count = sw_state.handshake_count + 2'd1;
                    r.read_data = HANDSHAKE_BUSY;
                  end
                end else begin
                  r.read_data = HANDSHAKE_READY;
                end
              end
              default: r.read_data = '0;
            endcase
          end
        end
      end
      OP_WRITE: begin
        if (it.offset == TYPE_REG_OFFSET) begin
          sw_state.control_35 = it.write_data[7];
          sw_state.select_35 = it.write_data[6];
        end else begin
          apply_switch(it.offset[3:0]);
          if (it.offset[0] && sw_state.q7_latch && sw_state.q6_latch) begin
            if (!sw_state.motor_flag) begin
              sw_state.mode_bits = it.write_data[4:0] & MODE_MASK;
            end else if (!sw_state.enable_two) begin
              r.write_valid = 1'b1;
              r.write_byte = it.write_data;
            end
          end
        end
      end
      OP_TICK: begin
        if (sw_state.motor_flag && sw_state.spindown_flag) begin
          if (sw_state.spindown_left != 8'd0) begin
            sw_state.spindown_left = sw_state.spindown_left - 8'd1;
          end
          if (sw_state.spindown_left == 8'd0) begin
            sw_state.motor_flag = 1'b0;
            sw_state.spindown_flag = 1'b0;
          end
        end
        r.flush = !sw_state.motor_flag || sw_state.spindown_flag;
      end
      default: ;
    endcase
    r.step_valid = step_fire;
    r.step_arg = step_code;
    r.drive_is_35 = sw_state.select_35;
    r.drive_number = sw_state.selected_drive;
    r.motor_running = sw_state.motor_flag;
    r.sense_code = {sw_state.phase_lines[2], sw_state.phase_lines[1],
                    sw_state.phase_lines[0], sw_state.control_35};
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      sw_state = '0;
      spindown_frames = SPINDOWN_RESET;
      pending_responses.delete();
    end else begin
      if (cfg_write_en) begin
        spindown_frames = cfg_write_data;
      end
      if (out_valid && out_ready) begin
        if (pending_responses.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual %h",
                   $time, out_data);
          fail_total++;
        end else begin
          want = pending_responses.pop_front();
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("step_valid", 8'(want.step_valid), 8'(out_data.step_valid));
          check_field("step_arg", 8'(want.step_arg), 8'(out_data.step_arg));
          check_field("write_valid", 8'(want.write_valid), 8'(out_data.write_valid));
          check_field("write_byte", want.write_byte, out_data.write_byte);
          check_field("read_taken", 8'(want.read_taken), 8'(out_data.read_taken));
          check_field("flush", 8'(want.flush), 8'(out_data.flush));
          check_field("drive_is_35", 8'(want.drive_is_35), 8'(out_data.drive_is_35));
          check_field("drive_number", 8'(want.drive_number), 8'(out_data.drive_number));
          check_field("motor_running", 8'(want.motor_running),
                      8'(out_data.motor_running));
          check_field("sense_code", 8'(want.sense_code), 8'(out_data.sense_code));
        end
      end
      if (in_valid && in_ready) begin
        predict_switch_response(in_data, want);
        pending_responses.push_back(want);
      end
    end
    pending <= pending_responses.size();
    error_count <= fail_total;
  end

endmodule

[verif/floppy_controller_soft_switches_core_test.sv]
module floppy_controller_soft_switches_core_test;
  import fcss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] SW_PHASE0_ON = 4'h1;
  localparam logic [3:0] SW_PHASE1_ON = 4'h3;
  localparam logic [3:0] SW_PHASE3_ON = 4'h7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_write_en = 1'b0;
  logic [7:0] cfg_write_data = '0;
  int         error_count;
  int         pending;

  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 77;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  logic [7:0]  spindown_setting = SPINDOWN_RESET;

  floppy_controller_soft_switches_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  fcss_result_checker result_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .error_count   (error_count),
    .pending       (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic in_item_t mk(input logic [1:0] op, input logic [5:0] offset,
                                  input logic [7:0] wd, input logic [7:0] dd,
                                  input logic ds);
    in_item_t it;
    it.op = op;
    it.offset = offset;
    it.write_data = wd;
    it.drive_data = dd;
    it.drive_sense = ds;
    return it;
  endfunction

  function automatic in_item_t rnd_item(input logic [1:0] op, input logic [5:0] offset);
    return mk(op, offset, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
  endfunction

  function automatic in_item_t sw_item(input logic [1:0] op, input logic [3:0] sw);
    logic [5:0] offset;
    offset = {2'b00, sw};
    offset[5:4] = 2'($urandom_range(3));
    return rnd_item(op, offset);
  endfunction

  function automatic in_item_t switch_access(input logic [3:0] sw);
    return sw_item($urandom_range(1) ? OP_WRITE : OP_READ, sw);
  endfunction

  function automatic in_item_t noise_item();
    logic [1:0] op;
    logic [5:0] offset;
    op = ($urandom_range(15) == 0) ? OP_UNUSED : 2'($urandom_range(2));
    offset = ($urandom_range(5) == 0) ? TYPE_REG_OFFSET : 6'($urandom_range(63));
    return rnd_item(op, offset);
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.op != OP_UNUSED) sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_spindown(input logic [7:0] frames);
    drain();
    cfg_write_en <= 1'b1;
    cfg_write_data <= frames;
    spindown_setting = frames;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned start;
    int unsigned n;
    start = sent_items;
    while (sent_items - start < target) begin
      case ($urandom_range(7))
        0, 1: send_item(noise_item());
        2: begin
          send_item(switch_access(SW_MOTOR_ON));
          send_item(switch_access(SW_MOTOR_OFF));
          n = ($urandom_range(7) == 0) ? spindown_setting + 2 : $urandom_range(8);
          repeat (n) send_item(rnd_item(OP_TICK, 6'($urandom_range(63))));
        end
        3: begin
          send_item(switch_access(SW_Q6_SET));
          send_item(switch_access(SW_Q7_SET));
          if ($urandom_range(2) == 0) send_item(switch_access(SW_MOTOR_ON));
          send_item(rnd_item(OP_WRITE, 6'($urandom_range(63)) | 6'd1));
        end
        4: begin
          send_item(switch_access(SW_PHASE1_ON));
          send_item(switch_access(SW_PHASE3_ON));
          send_item(switch_access(SW_Q7_SET));
          repeat ($urandom_range(1, 6)) send_item(sw_item(OP_READ, SW_Q6_CLEAR));
        end
        5: begin
          send_item(switch_access(SW_MOTOR_ON));
          send_item(switch_access($urandom_range(1) ? SW_Q6_SET : SW_Q6_CLEAR));
          send_item(switch_access(SW_Q7_CLEAR));
          repeat ($urandom_range(1, 6)) begin
            send_item(rnd_item(OP_READ, 6'($urandom_range(63)) & 6'h3E));
          end
        end
        6: begin
          send_item(switch_access(SW_MOTOR_ON));
          if ($urandom_range(1)) send_item(rnd_item(OP_WRITE, TYPE_REG_OFFSET));
          repeat ($urandom_range(2, 8)) send_item(switch_access(4'($urandom_range(7))));
        end
        default: send_item(rnd_item($urandom_range(1) ? OP_WRITE : OP_READ,
                                    TYPE_REG_OFFSET));
      endcase
    end
  endtask

  initial begin
    in_item_t   directed[$];
    logic [7:0] frames;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk(OP_READ,  TYPE_REG_OFFSET, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, TYPE_REG_OFFSET, 8'hFF, 8'hFF, 1'b1));
    directed.push_back(mk(OP_READ,  TYPE_REG_OFFSET, 8'h00, 8'hFF, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q6_SET}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q7_SET}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q7_SET}, 8'hFF, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_MOTOR_ON}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q7_SET}, 8'h5A, 8'hFF, 1'b1));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_PHASE0_ON}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_READ,  {2'b00, SW_PHASE3_ON}, 8'hFF, 8'hFF, 1'b1));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_MOTOR_OFF}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_PHASE1_ON}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q6_CLEAR}, 8'h00, 8'h00, 1'b0));
    repeat (4) directed.push_back(mk(OP_READ, {2'b10, SW_Q6_CLEAR}, 8'h00, 8'hA5, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b01, SW_MOTOR_ON}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q6_SET}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_Q7_SET}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, TYPE_REG_OFFSET, 8'h40, 8'h00, 1'b0));
    directed.push_back(mk(OP_WRITE, {2'b00, SW_PHASE3_ON}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_READ,  {2'b00, SW_Q7_CLEAR}, 8'h00, 8'h00, 1'b0));
    directed.push_back(mk(OP_TICK,  6'h00, 8'hFF, 8'hFF, 1'b1));
    directed.push_back(mk(OP_UNUSED, {2'b11, SW_Q7_SET}, 8'hFF, 8'hFF, 1'b1));
    directed.push_back(mk(OP_READ,  {2'b11, SW_Q6_CLEAR}, 8'h00, 8'h00, 1'b1));
    foreach (directed[i]) send_item(directed[i]);

    for (int phase_idx = 0; phase_idx < 3; phase_idx++) begin
      case (phase_idx)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        case (phase_idx * 3 + seg)
          0, 4:    frames = 8'd1;
          1, 8:    frames = 8'd255;
          default: frames = 8'($urandom_range(2, 254));
        endcase
        set_spindown(frames);
        run_random(150);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/fcss_pkg.sv
sv/fcss_logic.sv
sv/fcss_out_queue.sv
sv/floppy_controller_soft_switches_core.sv
verif/fcss_result_checker.sv
verif/floppy_controller_soft_switches_core_test.sv
